/* design/ikarm_pkg.sv */
package ikarm_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ANG_BITS      = 30;
    localparam int GUARD_BITS    = 24;

    localparam int CFG_W   = 18;
    localparam int POS_W   = 19;
    localparam int OUT_W   = 21;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // CORDIC operand, datapath and angle widths
    localparam int OPD_W = 21;
    localparam int CW_W  = 48;
    localparam int ANG_W = 34;

    // square root: radicand and root widths
    localparam int SQ_IN_W  = 38;
    localparam int SQ_OUT_W = 19;

    // divider: dividend/divisor width and quotient width
    localparam int DIV_W   = 38;
    localparam int DIV_Q_W = FRAC_BITS + 1;

    localparam logic [2:0] REG_BASE_HEIGHT      = 3'd0;
    localparam logic [2:0] REG_SHOULDER_OFFSET  = 3'd1;
    localparam logic [2:0] REG_UPPER_ARM_LENGTH = 3'd2;
    localparam logic [2:0] REG_FOREARM_LENGTH   = 3'd3;
    localparam logic [2:0] REG_GRIPPER_LENGTH   = 3'd4;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [10] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021688,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149
    };

    // atan(2^-i) at 30 fraction bits; plain 2^(30-i) from stage ten on
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] res;
        if (i < 10)
        begin
            res = ATAN_TAB[i];
        end
        else if (i > ANG_BITS)
        begin
            res = '0;
        end
        else
        begin
            res = ANG_W'(64'sd1 <<< (ANG_BITS - i));
        end
        return res;
    endfunction

    typedef struct packed {
        logic [CFG_W-1:0] base_height;
        logic [CFG_W-1:0] shoulder_offset;
        logic [CFG_W-1:0] upper_arm_length;
        logic [CFG_W-1:0] forearm_length;
        logic [CFG_W-1:0] gripper_length;
    } cfg_t;

    // per-beat values carried alongside the arithmetic units
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [OPD_W-1:0] rp;
        logic signed [OPD_W-1:0] dz;
        logic signed [FRAC_BITS+1:0] c;
        logic                    unreach;
        logic                    neg;
    } sb_t;

endpackage

/* design/ikarm_cfg.sv */
module ikarm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ikarm_pkg::ADDR_W-1:0]      paddr,
    input  logic [ikarm_pkg::DATA_W-1:0]      pwdata,
    output logic [ikarm_pkg::DATA_W-1:0]      prdata,
    output ikarm_pkg::cfg_t                   cfg
);

    localparam int CW = ikarm_pkg::CFG_W;

    ikarm_pkg::cfg_t cfg_reg;
    logic [2:0]      idx;
    logic            wr;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_height      <= CW'(23462);
            cfg_reg.shoulder_offset  <= CW'(3277);
            cfg_reg.upper_arm_length <= CW'(19661);
            cfg_reg.forearm_length   <= CW'(16384);
            cfg_reg.gripper_length   <= CW'(13894);
        end
        else if (wr)
        begin
            unique case (idx)
                ikarm_pkg::REG_BASE_HEIGHT:      cfg_reg.base_height      <= pwdata[CW-1:0];
                ikarm_pkg::REG_SHOULDER_OFFSET:  cfg_reg.shoulder_offset  <= pwdata[CW-1:0];
                ikarm_pkg::REG_UPPER_ARM_LENGTH: cfg_reg.upper_arm_length <= pwdata[CW-1:0];
                ikarm_pkg::REG_FOREARM_LENGTH:   cfg_reg.forearm_length   <= pwdata[CW-1:0];
                ikarm_pkg::REG_GRIPPER_LENGTH:   cfg_reg.gripper_length   <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ikarm_pkg::REG_BASE_HEIGHT:      prdata = 32'(cfg_reg.base_height);
            ikarm_pkg::REG_SHOULDER_OFFSET:  prdata = 32'(cfg_reg.shoulder_offset);
            ikarm_pkg::REG_UPPER_ARM_LENGTH: prdata = 32'(cfg_reg.upper_arm_length);
            ikarm_pkg::REG_FOREARM_LENGTH:   prdata = 32'(cfg_reg.forearm_length);
            ikarm_pkg::REG_GRIPPER_LENGTH:   prdata = 32'(cfg_reg.gripper_length);
            default:                         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* design/ikarm_sqrt.sv */
module ikarm_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              v_i,
    input  logic [ikarm_pkg::SQ_IN_W-1:0]     rad_i,
    input  ikarm_pkg::sb_t                    sb_i,
    output logic                              v_o,
    output logic [ikarm_pkg::SQ_OUT_W-1:0]    root_o,
    output ikarm_pkg::sb_t                    sb_o
);

    // one root bit per stage, MSB first; floor square root
    localparam int N  = ikarm_pkg::SQ_OUT_W;
    localparam int CW = ikarm_pkg::SQ_IN_W + 3;

    logic [CW-1:0]   rem_w  [N+1];
    logic [N-1:0]    root_w [N+1];
    logic            v_w    [N+1];
    ikarm_pkg::sb_t  sb_w   [N+1];

    assign rem_w[0]  = CW'(rad_i);
    assign root_w[0] = '0;
    assign v_w[0]    = v_i;
    assign sb_w[0]   = sb_i;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;

        logic [CW-1:0]  trial;
        logic [CW-1:0]  rem_reg;
        logic [N-1:0]   root_reg;
        logic           v_reg;
        ikarm_pkg::sb_t sb_reg;

        // (root + 2^B)^2 - root^2
        assign trial = (CW'(root_w[k]) << (B + 1)) + (CW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_w[k] >= trial)
                begin
                    rem_reg  <= rem_w[k] - trial;
                    root_reg <= root_w[k] | (N'(1) << B);
                end
                else
                begin
                    rem_reg  <= rem_w[k];
                    root_reg <= root_w[k];
                end
                sb_reg <= sb_w[k];
            end
        end

        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign v_w[k+1]    = v_reg;
        assign sb_w[k+1]   = sb_reg;
    end

    assign v_o    = v_w[N];
    assign root_o = root_w[N];
    assign sb_o   = sb_w[N];

endmodule

/* design/ikarm_div.sv */
module ikarm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              v_i,
    input  logic [ikarm_pkg::DIV_W-1:0]       num_i,
    input  logic [ikarm_pkg::DIV_W-1:0]       den_i,
    input  ikarm_pkg::sb_t                    sb_i,
    output logic                              v_o,
    output logic [ikarm_pkg::DIV_Q_W-1:0]     q_o,
    output ikarm_pkg::sb_t                    sb_o
);

    // floor(num * 2^FRAC_BITS / den) for num <= den; one quotient bit per stage
    localparam int N  = ikarm_pkg::DIV_Q_W;
    localparam int RW = ikarm_pkg::DIV_W + 1;

    logic [RW-1:0]   rem_w [N+1];
    logic [N-1:0]    q_w   [N+1];
    logic            v_w   [N+1];
    ikarm_pkg::sb_t  sb_w  [N+1];

    assign rem_w[0] = RW'(num_i);
    assign q_w[0]   = '0;
    assign v_w[0]   = v_i;
    assign sb_w[0]  = sb_i;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [RW-1:0]  shifted;
        logic [RW-1:0]  rem_reg;
        logic [N-1:0]   q_reg;
        logic           v_reg;
        ikarm_pkg::sb_t sb_reg;

        if (k == 0)
        begin : g_first
            assign shifted = rem_w[k];
        end
        else
        begin : g_rest
            assign shifted = rem_w[k] << 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (shifted >= RW'(den_i))
                begin
                    rem_reg <= shifted - RW'(den_i);
                    q_reg   <= {q_w[k][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    q_reg   <= {q_w[k][N-2:0], 1'b0};
                end
                sb_reg <= sb_w[k];
            end
        end

        assign rem_w[k+1] = rem_reg;
        assign q_w[k+1]   = q_reg;
        assign v_w[k+1]   = v_reg;
        assign sb_w[k+1]  = sb_reg;
    end

    assign v_o  = v_w[N];
    assign q_o  = q_w[N];
    assign sb_o = sb_w[N];

endmodule

/* design/ikarm_cordic.sv */
module ikarm_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   v_i,
    input  logic signed [ikarm_pkg::OPD_W-1:0]     y_i,
    input  logic signed [ikarm_pkg::OPD_W-1:0]     x_i,
    input  ikarm_pkg::sb_t                         sb_i,
    output logic                                   v_o,
    output logic signed [ikarm_pkg::ANG_W-1:0]     ang_o,
    output ikarm_pkg::sb_t                         sb_o
);

    // vectoring atan2: one set-up stage, then one rotation per stage
    localparam int N  = ikarm_pkg::CORDIC_STAGES;
    localparam int W  = ikarm_pkg::CW_W;
    localparam int AW = ikarm_pkg::ANG_W;

    logic signed [W-1:0]  xe;
    logic signed [W-1:0]  ye;
    logic                 fix_c;
    logic signed [AW-1:0] fval_c;
    logic signed [AW-1:0] z0_c;
    logic signed [W-1:0]  xa_c;
    logic signed [W-1:0]  ya_c;

    logic signed [W-1:0]  x_w    [N+1];
    logic signed [W-1:0]  y_w    [N+1];
    logic signed [AW-1:0] z_w    [N+1];
    logic                 fix_w  [N+1];
    logic signed [AW-1:0] fval_w [N+1];
    logic                 v_w    [N+1];
    ikarm_pkg::sb_t       sb_w   [N+1];

    logic signed [W-1:0]  x0_reg;
    logic signed [W-1:0]  y0_reg;
    logic signed [AW-1:0] z0_reg;
    logic                 fix0_reg;
    logic signed [AW-1:0] fval0_reg;
    logic                 v0_reg;
    ikarm_pkg::sb_t       sb0_reg;

    assign xe = W'(x_i);
    assign ye = W'(y_i);

    always_comb
    begin
        fix_c  = (x_i == '0) || (y_i == '0);
        fval_c = '0;
        if (x_i == '0)
        begin
            if (y_i > 0)
            begin
                fval_c = ikarm_pkg::HALF_PI_Q30;
            end
            else if (y_i < 0)
            begin
                fval_c = -ikarm_pkg::HALF_PI_Q30;
            end
        end
        else if (x_i < 0)
        begin
            fval_c = ikarm_pkg::PI_Q30;
        end

        // left half plane: turn by pi first
        if (x_i < 0)
        begin
            z0_c = (y_i >= 0) ? ikarm_pkg::PI_Q30 : -ikarm_pkg::PI_Q30;
            xa_c = -xe;
            ya_c = -ye;
        end
        else
        begin
            z0_c = '0;
            xa_c = xe;
            ya_c = ye;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= v_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= xa_c <<< ikarm_pkg::GUARD_BITS;
            y0_reg    <= ya_c <<< ikarm_pkg::GUARD_BITS;
            z0_reg    <= z0_c;
            fix0_reg  <= fix_c;
            fval0_reg <= fval_c;
            sb0_reg   <= sb_i;
        end
    end

    assign x_w[0]    = x0_reg;
    assign y_w[0]    = y0_reg;
    assign z_w[0]    = z0_reg;
    assign fix_w[0]  = fix0_reg;
    assign fval_w[0] = fval0_reg;
    assign v_w[0]    = v0_reg;
    assign sb_w[0]   = sb0_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic signed [AW-1:0] STEP = ikarm_pkg::atan_step(k);

        logic signed [W-1:0]  xs;
        logic signed [W-1:0]  ys;
        logic signed [W-1:0]  x_reg;
        logic signed [W-1:0]  y_reg;
        logic signed [AW-1:0] z_reg;
        logic                 fix_reg;
        logic signed [AW-1:0] fval_reg;
        logic                 v_reg;
        ikarm_pkg::sb_t       sb_reg;

        assign xs = x_w[k] >>> k;
        assign ys = y_w[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_w[k][W-1])
                begin
                    x_reg <= x_w[k] + ys;
                    y_reg <= y_w[k] - xs;
                    z_reg <= z_w[k] + STEP;
                end
                else
                begin
                    x_reg <= x_w[k] - ys;
                    y_reg <= y_w[k] + xs;
                    z_reg <= z_w[k] - STEP;
                end
                fix_reg  <= fix_w[k];
                fval_reg <= fval_w[k];
                sb_reg   <= sb_w[k];
            end
        end

        assign x_w[k+1]    = x_reg;
        assign y_w[k+1]    = y_reg;
        assign z_w[k+1]    = z_reg;
        assign fix_w[k+1]  = fix_reg;
        assign fval_w[k+1] = fval_reg;
        assign v_w[k+1]    = v_reg;
        assign sb_w[k+1]   = sb_reg;
    end

    assign v_o   = v_w[N];
    assign ang_o = fix_w[N] ? fval_w[N] : z_w[N];
    assign sb_o  = sb_w[N];

endmodule

/* design/four_axis_arm_inverse_kinematics.sv */
// Inverse kinematics for a four-axis articulated arm.
//
// Input channel (in_valid / in_stall): one beat carries a target point
// x_pos, y_pos, z_pos in metres, signed, 16 fraction bits.
// Output channel (out_valid / out_stall): one beat per input beat carrying
// base, shoulder, elbow and pitch angles in radians (signed, 16 fraction
// bits) and the unreachable flag (cosine was clamped).
// Link lengths are set over the APB port, registers at byte offsets 0..16
// (base height, shoulder offset, upper arm, forearm, gripper); write them
// only while the pipeline is empty.
//
// Throughput: one beat per cycle while the output queue is not full. The
// pipeline is the chain of two 19-stage square roots, a 17-stage divider
// and a 17-stage CORDIC plus 13 glue stages and the output register.
// Reset: pipeline emptied, registers load the default arm geometry.
// Output stall: a two-entry output queue absorbs results; once full the
// whole pipeline holds and in_stall rises until a beat is taken.
module four_axis_arm_inverse_kinematics (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ikarm_pkg::ADDR_W-1:0]        paddr,
    input  logic [ikarm_pkg::DATA_W-1:0]        pwdata,
    output logic [ikarm_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ikarm_pkg::POS_W-1:0]  x_pos,
    input  logic signed [ikarm_pkg::POS_W-1:0]  y_pos,
    input  logic signed [ikarm_pkg::POS_W-1:0]  z_pos,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ikarm_pkg::OUT_W-1:0]  base_angle,
    output logic signed [ikarm_pkg::OUT_W-1:0]  shoulder_angle,
    output logic signed [ikarm_pkg::OUT_W-1:0]  elbow_angle,
    output logic signed [ikarm_pkg::OUT_W-1:0]  pitch_angle,
    output logic                                unreachable
);

    localparam int FB  = ikarm_pkg::FRAC_BITS;
    localparam int PW  = ikarm_pkg::POS_W;
    localparam int OW  = ikarm_pkg::OUT_W;
    localparam int DW  = ikarm_pkg::OPD_W;
    localparam int AW  = ikarm_pkg::ANG_W;
    localparam int SIW = ikarm_pkg::SQ_IN_W;
    localparam int SOW = ikarm_pkg::SQ_OUT_W;
    localparam int VW  = ikarm_pkg::DIV_W;
    localparam int QW  = ikarm_pkg::DIV_Q_W;
    localparam int CW  = ikarm_pkg::CFG_W;
    localparam int NW  = 42;                 // law-of-cosines numerator
    localparam int RSH = ikarm_pkg::ANG_BITS - FB;

    typedef struct packed {
        logic signed [OW-1:0] base;
        logic signed [OW-1:0] shoulder;
        logic signed [OW-1:0] elbow;
        logic signed [OW-1:0] pitch;
        logic                 unreach;
    } res_t;

    ikarm_pkg::cfg_t cfg;
    logic            adv;

    // ---------------- configuration ----------------
    ikarm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // geometry terms that depend on the registers only; the squares and
    // product are registered, then the sum and the denominator
    logic [2*CW-1:0] l2sq_reg;
    logic [2*CW-1:0] l3sq_reg;
    logic [2*CW-1:0] l23_reg;
    logic [VW-1:0]   lsq_reg;
    logic [VW-1:0]   den_reg;

    always_ff @(posedge clk)
    begin
        l2sq_reg <= cfg.upper_arm_length * cfg.upper_arm_length;
        l3sq_reg <= cfg.forearm_length * cfg.forearm_length;
        l23_reg  <= cfg.upper_arm_length * cfg.forearm_length;
        lsq_reg  <= VW'(l2sq_reg) + VW'(l3sq_reg);
        den_reg  <= {1'b0, l23_reg, 1'b0};
    end

    // ---------------- P1: capture, square x and y ----------------
    logic signed [2*PW-1:0] xx_c;
    logic signed [2*PW-1:0] yy_c;
    logic                   p1_v_reg;
    logic signed [PW-1:0]   p1_x_reg;
    logic signed [PW-1:0]   p1_y_reg;
    logic signed [PW-1:0]   p1_z_reg;
    logic [2*PW-2:0]        p1_xx_reg;
    logic [2*PW-2:0]        p1_yy_reg;

    assign xx_c = x_pos * x_pos;
    assign yy_c = y_pos * y_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_x_reg  <= x_pos;
            p1_y_reg  <= y_pos;
            p1_z_reg  <= z_pos;
            p1_xx_reg <= xx_c[2*PW-2:0];
            p1_yy_reg <= yy_c[2*PW-2:0];
        end
    end

    // ---------------- P2: x^2 + y^2 ----------------
    logic           p2_v_reg;
    logic [SIW-1:0] p2_ss_reg;
    ikarm_pkg::sb_t p2_sb_c;
    ikarm_pkg::sb_t p2_sb_reg;

    always_comb
    begin
        p2_sb_c   = '0;
        p2_sb_c.x = p1_x_reg;
        p2_sb_c.y = p1_y_reg;
        p2_sb_c.z = p1_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_ss_reg <= SIW'(p1_xx_reg) + SIW'(p1_yy_reg);
            p2_sb_reg <= p2_sb_c;
        end
    end

    // ---------------- radial distance ----------------
    logic           sq1_v;
    logic [SOW-1:0] sq1_r;
    ikarm_pkg::sb_t sq1_sb;

    ikarm_sqrt u_sqrt_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .v_i    (p2_v_reg),
        .rad_i  (p2_ss_reg),
        .sb_i   (p2_sb_reg),
        .v_o    (sq1_v),
        .root_o (sq1_r),
        .sb_o   (sq1_sb)
    );

    // ---------------- P3: offsets into the arm plane ----------------
    logic signed [DW-1:0] rp_c;
    logic signed [DW-1:0] dz_c;
    ikarm_pkg::sb_t       p3_sb_c;
    logic                 p3_v_reg;
    ikarm_pkg::sb_t       p3_sb_reg;

    assign rp_c = $signed({2'b00, sq1_r}) - $signed({3'b000, cfg.shoulder_offset})
                  - $signed({3'b000, cfg.gripper_length});
    assign dz_c = $signed({{(DW-PW){sq1_sb.z[PW-1]}}, sq1_sb.z})
                  - $signed({3'b000, cfg.base_height});

    always_comb
    begin
        p3_sb_c    = sq1_sb;
        p3_sb_c.rp = rp_c;
        p3_sb_c.dz = dz_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p3_v_reg <= sq1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_sb_reg <= p3_sb_c;
        end
    end

    // ---------------- P4: squares ----------------
    logic signed [2*DW-1:0] rp2_c;
    logic signed [2*DW-1:0] dz2_c;
    logic                   p4_v_reg;
    logic [NW-3:0]          p4_rp2_reg;
    logic [NW-3:0]          p4_dz2_reg;
    ikarm_pkg::sb_t         p4_sb_reg;

    assign rp2_c = p3_sb_reg.rp * p3_sb_reg.rp;
    assign dz2_c = p3_sb_reg.dz * p3_sb_reg.dz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_rp2_reg <= rp2_c[NW-3:0];
            p4_dz2_reg <= dz2_c[NW-3:0];
            p4_sb_reg  <= p3_sb_reg;
        end
    end

    // ---------------- P5: numerator ----------------
    logic                 p5_v_reg;
    logic signed [NW-1:0] p5_num_reg;
    ikarm_pkg::sb_t       p5_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_num_reg <= $signed({2'b00, p4_rp2_reg}) + $signed({2'b00, p4_dz2_reg})
                          - $signed({{(NW-VW){1'b0}}, lsq_reg});
            p5_sb_reg  <= p4_sb_reg;
        end
    end

    // ---------------- P6: reach check, magnitude ----------------
    logic signed [NW-1:0] den_s;
    logic signed [NW-1:0] mag_c;
    logic                 unreach_c;
    ikarm_pkg::sb_t       p6_sb_c;
    logic                 p6_v_reg;
    logic [VW-1:0]        p6_mag_reg;
    ikarm_pkg::sb_t       p6_sb_reg;

    assign den_s     = $signed({{(NW-VW){1'b0}}, den_reg});
    assign unreach_c = (den_reg == '0) || (p5_num_reg > den_s) || (p5_num_reg < -den_s);
    assign mag_c     = p5_num_reg[NW-1] ? -p5_num_reg : p5_num_reg;

    always_comb
    begin
        p6_sb_c         = p5_sb_reg;
        p6_sb_c.unreach = unreach_c;
        p6_sb_c.neg     = p5_num_reg[NW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p6_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p6_v_reg <= p5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_mag_reg <= mag_c[VW-1:0];
            p6_sb_reg  <= p6_sb_c;
        end
    end

    // ---------------- elbow cosine ----------------
    logic           dv_v;
    logic [QW-1:0]  dv_q;
    ikarm_pkg::sb_t dv_sb;

    ikarm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .v_i   (p6_v_reg),
        .num_i (p6_mag_reg),
        .den_i (den_reg),
        .sb_i  (p6_sb_reg),
        .v_o   (dv_v),
        .q_o   (dv_q),
        .sb_o  (dv_sb)
    );

    // ---------------- P7: clamp and sign ----------------
    logic [QW-1:0]          m_c;
    logic signed [QW:0]     c_c;
    ikarm_pkg::sb_t         p7_sb_c;
    logic                   p7_v_reg;
    ikarm_pkg::sb_t         p7_sb_reg;

    assign m_c = dv_sb.unreach ? (QW'(1) << FB) : dv_q;
    assign c_c = dv_sb.neg ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});

    always_comb
    begin
        p7_sb_c   = dv_sb;
        p7_sb_c.c = c_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p7_v_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_sb_reg <= p7_sb_c;
        end
    end

    // ---------------- P8/P9: 1 - c^2 ----------------
    logic signed [2*QW+1:0] csq_c;
    logic                   p8_v_reg;
    logic [2*FB:0]          p8_csq_reg;
    ikarm_pkg::sb_t         p8_sb_reg;
    logic                   p9_v_reg;
    logic [SIW-1:0]         p9_rad_reg;
    ikarm_pkg::sb_t         p9_sb_reg;

    assign csq_c = p7_sb_reg.c * p7_sb_reg.c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p8_v_reg <= 1'b0;
            p9_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p8_v_reg <= p7_v_reg;
            p9_v_reg <= p8_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_csq_reg <= csq_c[2*FB:0];
            p8_sb_reg  <= p7_sb_reg;
            p9_rad_reg <= SIW'((2*FB+1)'(1) << (2*FB)) - SIW'(p8_csq_reg);
            p9_sb_reg  <= p8_sb_reg;
        end
    end

    // ---------------- elbow sine ----------------
    logic           sq2_v;
    logic [SOW-1:0] sq2_s;
    ikarm_pkg::sb_t sq2_sb;

    ikarm_sqrt u_sqrt_s (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .v_i    (p9_v_reg),
        .rad_i  (p9_rad_reg),
        .sb_i   (p9_sb_reg),
        .v_o    (sq2_v),
        .root_o (sq2_s),
        .sb_o   (sq2_sb)
    );

    // ---------------- P10/P11: forearm projection ----------------
    logic [CW+SOW-1:0]          ls_c;
    logic signed [CW+QW+1:0]    lc_c;
    logic                       p10_v_reg;
    logic [FB:0]                p10_s_reg;
    logic [CW+SOW-1:0]          p10_ls_reg;
    logic signed [CW+QW+1:0]    p10_lc_reg;
    ikarm_pkg::sb_t             p10_sb_reg;
    logic                       p11_v_reg;
    logic signed [DW-1:0]       p11_s_reg;
    logic signed [DW-1:0]       p11_t3_reg;
    logic signed [DW-1:0]       p11_t4_reg;
    ikarm_pkg::sb_t             p11_sb_reg;

    assign ls_c = (CW+SOW)'(cfg.forearm_length) * (CW+SOW)'(sq2_s);
    assign lc_c = $signed({1'b0, cfg.forearm_length}) * sq2_sb.c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p10_v_reg <= 1'b0;
            p11_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p10_v_reg <= sq2_v;
            p11_v_reg <= p10_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_s_reg  <= sq2_s[FB:0];
            p10_ls_reg <= ls_c;
            p10_lc_reg <= lc_c;
            p10_sb_reg <= sq2_sb;
            p11_s_reg  <= $signed(DW'(p10_s_reg));
            p11_t3_reg <= $signed(p10_ls_reg[FB+DW-1:FB]);
            p11_t4_reg <= $signed({3'b000, cfg.upper_arm_length})
                          + $signed(p10_lc_reg[FB+DW-1:FB]);
            p11_sb_reg <= p10_sb_reg;
        end
    end

    // ---------------- four atan2 units in parallel ----------------
    logic signed [DW-1:0] bx_c;
    logic signed [DW-1:0] by_c;
    logic signed [DW-1:0] ec_c;
    logic                 cb_v;
    logic signed [AW-1:0] a_base;
    logic signed [AW-1:0] a_dr;
    logic signed [AW-1:0] a_el;
    logic signed [AW-1:0] a_tt;
    ikarm_pkg::sb_t       cb_sb;

    assign bx_c = DW'(p11_sb_reg.x);
    assign by_c = DW'(p11_sb_reg.y);
    assign ec_c = DW'(p11_sb_reg.c);

    // base carries the beat's side data; the others run in lockstep
    ikarm_cordic u_cordic_base (
        .clk (clk), .rst_n (rst_n), .adv (adv), .v_i (p11_v_reg),
        .y_i (by_c), .x_i (bx_c), .sb_i (p11_sb_reg),
        .v_o (cb_v), .ang_o (a_base), .sb_o (cb_sb)
    );

    ikarm_cordic u_cordic_plane (
        .clk (clk), .rst_n (rst_n), .adv (adv), .v_i (p11_v_reg),
        .y_i (p11_sb_reg.dz), .x_i (p11_sb_reg.rp), .sb_i ('0),
        .v_o (), .ang_o (a_dr), .sb_o ()
    );

    ikarm_cordic u_cordic_elbow (
        .clk (clk), .rst_n (rst_n), .adv (adv), .v_i (p11_v_reg),
        .y_i (p11_s_reg), .x_i (ec_c), .sb_i ('0),
        .v_o (), .ang_o (a_el), .sb_o ()
    );

    ikarm_cordic u_cordic_link (
        .clk (clk), .rst_n (rst_n), .adv (adv), .v_i (p11_v_reg),
        .y_i (p11_t3_reg), .x_i (p11_t4_reg), .sb_i ('0),
        .v_o (), .ang_o (a_tt), .sb_o ()
    );

    // ---------------- P12/P13: difference and rounding ----------------
    logic signed [AW:0]   base_rnd_c;
    logic signed [AW:0]   el_rnd_c;
    logic signed [AW+1:0] sh_rnd_c;
    logic                 p12_v_reg;
    logic signed [AW:0]   p12_diff_reg;
    logic signed [OW-1:0] p12_base_reg;
    logic signed [OW-1:0] p12_el_reg;
    logic                 p12_un_reg;
    res_t                 p13_res_c;
    logic                 p13_v_reg;
    res_t                 p13_res_reg;
    res_t                 push_res;

    // round to FRAC_BITS: add half, floor shift
    assign base_rnd_c = ($signed({a_base[AW-1], a_base}) + (AW+1)'(1 << (RSH - 1))) >>> RSH;
    assign el_rnd_c   = ($signed({a_el[AW-1], a_el}) + (AW+1)'(1 << (RSH - 1))) >>> RSH;
    assign sh_rnd_c   = ($signed({p12_diff_reg[AW], p12_diff_reg})
                         + (AW+2)'(1 << (RSH - 1))) >>> RSH;

    always_comb
    begin
        p13_res_c.base     = p12_base_reg;
        p13_res_c.shoulder = sh_rnd_c[OW-1:0];
        p13_res_c.elbow    = p12_el_reg;
        p13_res_c.pitch    = '0;
        p13_res_c.unreach  = p12_un_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p12_v_reg <= 1'b0;
            p13_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p12_v_reg <= cb_v;
            p13_v_reg <= p12_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p12_diff_reg <= $signed({a_dr[AW-1], a_dr}) - $signed({a_tt[AW-1], a_tt});
            p12_base_reg <= base_rnd_c[OW-1:0];
            p12_el_reg   <= el_rnd_c[OW-1:0];
            p12_un_reg   <= cb_sb.unreach;
            p13_res_reg  <= p13_res_c;
        end
    end

    always_comb
    begin
        push_res       = p13_res_reg;
        push_res.pitch = -p13_res_reg.shoulder - p13_res_reg.elbow;
    end

    // ---------------- output queue ----------------
    // two entries: one result can wait while the pipeline still moves
    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    res_t       head;

    assign adv      = (cnt_reg != 2'd2);
    assign in_stall = !adv;
    assign push     = p13_v_reg && adv;
    assign pop      = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign head           = q_reg[rd_ptr_reg];
    assign out_valid      = (cnt_reg != 2'd0);
    assign base_angle     = head.base;
    assign shoulder_angle = head.shoulder;
    assign elbow_angle    = head.elbow;
    assign pitch_angle    = head.pitch;
    assign unreachable    = head.unreach;

endmodule
